// File: hdl/sha256_pkg.sv
// SHA-256 shared package: round constants, initial hash values, round helpers.
// Used by sha256_ctrl, sha256_dp and the top level. No dependencies.
`timescale 1ns / 1ps
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Controller-to-datapath commands
  typedef struct packed {
    logic load_byte;   // write byte into block buffer at fill position
    logic pad_sel;     // byte source: 0 = input, 1 = pad/length generator
    logic start;       // copy chaining value into working variables
    logic round_en;    // perform one round
    logic finish;      // add working variables into chaining value
    logic clear;       // return to initial state for next message
    logic count_en;    // advance message byte count
  } sha256_cmd_t;

  // Datapath-to-controller status
  typedef struct packed {
    logic       last_round;  // round index is 63
    logic [5:0] fill;        // bytes held in the current block
    logic       len_blk;     // current pad block carries the bit length
  } sha256_sts_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: hdl/sha256_dp.sv
// SHA-256 datapath: block buffer / schedule window, working variables,
// chaining value, byte counter and pad byte generator. Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::sha256_cmd_t cmd,
  input  logic [7:0]            in_byte,
  output sha256_pkg::sha256_sts_t sts,
  output logic [255:0]          digest
);

  sha256_pkg::word_t w_r [16];
  sha256_pkg::word_t v_r [8];
  sha256_pkg::word_t h_r [8];
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;
  logic [60:0] cnt_r;
  logic        pad_done_r;
  logic        spill_r;      // pad block too full for the length, zeros only

  logic [7:0]  pad_byte;
  logic [7:0]  byte_sel;
  logic [63:0] bit_len;
  logic [2:0]  len_idx;
  sha256_pkg::word_t w_cur, w15, w2, w7, g0, g1, s0, s1, ch, maj, t1, t2;

  assign bit_len = {cnt_r, 3'b000};
  assign len_idx = fill_r[2:0];

  // Pick the pad stream byte: 0x80 once, zeros, then the big-endian bit length
  always_comb begin
    if (!pad_done_r) pad_byte = sha256_pkg::PAD_BYTE;
    else if (!spill_r && fill_r >= sha256_pkg::LEN_POS) pad_byte = bit_len[(7 - len_idx) * 8 +: 8];
    else pad_byte = 8'h00;
    byte_sel = cmd.pad_sel ? pad_byte : in_byte;
  end

  // Round logic on the rolling schedule window
  always_comb begin
    w15 = w_r[rnd_r[3:0] + 4'd1];
    w2  = w_r[rnd_r[3:0] + 4'd14];
    w7  = w_r[rnd_r[3:0] + 4'd9];
    g0  = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
    g1  = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
    w_cur = (rnd_r < 6'd16) ? w_r[rnd_r[3:0]] : (w_r[rnd_r[3:0]] + g0 + w7 + g1);
    s1  = sha256_pkg::rotr(v_r[4], 6) ^ sha256_pkg::rotr(v_r[4], 11)
        ^ sha256_pkg::rotr(v_r[4], 25);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1  = v_r[7] + s1 + ch + sha256_pkg::round_k(rnd_r) + w_cur;
    s0  = sha256_pkg::rotr(v_r[0], 2) ^ sha256_pkg::rotr(v_r[0], 13)
        ^ sha256_pkg::rotr(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2  = s0 + maj;
  end

  // Schedule window: byte writes while filling, rolling words in rounds
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      w_r[fill_r[5:2]][(3 - fill_r[1:0]) * 8 +: 8] <= byte_sel;
    end else if (cmd.round_en) begin
      w_r[rnd_r[3:0]] <= w_cur;
    end
  end

  // Control registers and hash state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      fill_r     <= '0;
      rnd_r      <= '0;
      cnt_r      <= '0;
      pad_done_r <= 1'b0;
      spill_r    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sha256_pkg::INIT_H[i];
        v_r[i] <= '0;
      end
    end else begin
      if (cmd.load_byte) begin
        fill_r <= fill_r + 6'd1;
        if (cmd.pad_sel) begin
          pad_done_r <= 1'b1;
          // 0x80 past the length slot pushes the length into an extra block
          if (!pad_done_r) spill_r <= (fill_r >= sha256_pkg::LEN_POS) && (fill_r != 6'd63);
          else if (fill_r == 6'd63) spill_r <= 1'b0;
        end
      end
      if (cmd.count_en) cnt_r <= cnt_r + 61'd1;
      if (cmd.start) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        rnd_r <= '0;
      end else if (cmd.round_en) begin
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  assign sts.last_round = (rnd_r == 6'd63);
  assign sts.fill       = fill_r;
  assign sts.len_blk    = pad_done_r && !spill_r;
  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4], h_r[5], h_r[6], h_r[7]};

endmodule

// File: hdl/sha256_ctrl.sv
// SHA-256 controller: input handshake, padding sequence and compression control.
// Depends on sha256_pkg; drives sha256_dp through command/status structs.
`timescale 1ns / 1ps
module sha256_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic                    in_present,
  input  logic                    in_last,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  sha256_pkg::sha256_sts_t sts,
  output sha256_pkg::sha256_cmd_t cmd,
  output logic                    cap
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROUND, S_FINISH, S_PAD, S_DONE, S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   pad_mode_r, pad_mode_nxt;   // compression belongs to the pad run
  logic   out_valid_r, out_valid_nxt;
  logic   len_written_r;              // block holding the bit length went in
  logic   acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    pad_mode_nxt  = pad_mode_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cap           = 1'b0;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load_byte = in_present;
          cmd.count_en  = in_present;
          pad_mode_nxt  = in_last;
          if (in_present && sts.fill == 6'd63) state_nxt = S_START;
          else if (in_last) state_nxt = S_PAD;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (sts.last_round) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (!pad_mode_r) state_nxt = S_IDLE;
        else if (sts.fill == 6'd0 && len_written_r) state_nxt = S_DONE;
        else state_nxt = S_PAD;
      end
      S_PAD: begin
        // emit one pad stream byte per cycle
        cmd.load_byte = 1'b1;
        cmd.pad_sel   = 1'b1;
        if (sts.fill == 6'd63) state_nxt = S_START;
      end
      S_DONE: begin
        // capture the digest once the output register is free
        if (!out_valid_r || out_tready) begin
          cap           = 1'b1;
          out_valid_nxt = 1'b1;
          cmd.clear     = 1'b1;
          pad_mode_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pad_mode_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      len_written_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pad_mode_r  <= pad_mode_nxt;
      out_valid_r <= out_valid_nxt;
      // Length bytes end the block only when the full pad stream went in
      if (cmd.clear) len_written_r <= 1'b0;
      else if (cmd.pad_sel && sts.fill == 6'd63 && sts.len_blk) len_written_r <= 1'b1;
    end
  end

endmodule

// File: hdl/sha256_byte_stream_hasher_core.sv
// SHA-256 byte stream hasher, top level. Depends on sha256_pkg, sha256_ctrl,
// sha256_dp.
`timescale 1ns / 1ps
// One message byte is taken per cycle while a block fills; the 64th byte of a
// block starts a compression (one load, 64 rounds, one chaining add), during
// which in_tready is low. The last item runs the pad stream one byte per cycle
// up to the block end (on into an extra block when the pad spills), each block
// followed by a compression, and the digest then lands in the output register.
// The next message is taken while that digest waits; a following digest holds
// the block, with in_tready low, until the waiting one has been taken. The
// single shared round unit sets this sequence.
module sha256_byte_stream_hasher_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] byte_present
  input  logic         in_tlast,   // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata   // digest_word_0..3, word 0 in the lowest bits
);

  sha256_pkg::sha256_cmd_t cmd;
  sha256_pkg::sha256_sts_t sts;
  logic [255:0] digest;
  logic [255:0] out_data_r;
  logic         cap;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_present (in_tuser), .in_last (in_tlast),
    .out_tvalid, .out_tready, .sts, .cmd, .cap
  );

  sha256_dp u_dp (
    .clk, .rst_n, .cmd, .in_byte (in_tdata), .sts, .digest
  );

  // Hold the finished digest, word 0 lowest
  always_ff @(posedge clk) begin
    if (cap) out_data_r <= {digest[63:0], digest[127:64], digest[191:128], digest[255:192]};
  end

  assign out_tdata = out_data_r;

endmodule

// File: hdl/sha256_checker.sv
// Port-level checker for the SHA-256 hasher top level, bound in below.
// Depends on sha256_byte_stream_hasher_core ports only.
`timescale 1ns / 1ps
module sha256_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [255:0] out_tdata
);

  // A stalled digest holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("digest changed while stalled");

  // A last item cannot yield a digest in the next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !$rose(out_tvalid))
    else $error("digest too early");

  // Reset leaves no digest pending
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");

endmodule

bind sha256_byte_stream_hasher_core sha256_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast,
  .out_tvalid, .out_tready, .out_tdata
);

// File: tb/sv/sha256_byte_stream_hasher_core_test.sv
// Testbench for sha256_byte_stream_hasher_core: drives byte requests, predicts digests
// with an own SHA-256 model held in a scoreboard class. Depends on the RTL only.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_core_test;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [255:0] out_tdata;

  sha256_byte_stream_hasher_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Own digest model plus the queue of digests still owed by the block
  class digest_board;
    bit [31:0]  hv [8];
    bit [31:0]  blk [16];
    int         fill;
    bit [60:0]  nbytes;
    bit [255:0] owed [$];
    int         errors;
    int         digests;

    function new();
      errors = 0;
      digests = 0;
      restart();
    endfunction

    function void restart();
      hv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      foreach (blk[i]) blk[i] = '0;
      fill = 0;
      nbytes = '0;
    endfunction

    function bit [31:0] ror(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] kt [64];
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] t1, t2;
      kt = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      for (int i = 0; i < 64; i++) begin
        if (i < 16) w[i] = blk[i];
        else w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                    + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      v = hv;
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kt[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      foreach (hv[i]) hv[i] += v[i];
    endfunction

    function void put_byte(bit [7:0] b);
      blk[fill / 4][(3 - fill % 4) * 8 +: 8] = b;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    // Note one accepted request
    function void note_request(bit [7:0] b, bit present, bit last);
      bit [63:0] bits;
      if (present) begin
        put_byte(b);
        nbytes++;
      end
      if (!last) return;
      bits = {nbytes, 3'b000};
      put_byte(8'h80);
      while (fill != 56) put_byte(8'h00);
      for (int s = 56; s >= 0; s -= 8) put_byte(bits[s +: 8]);
      owed.push_back({hv[6], hv[7], hv[4], hv[5], hv[2], hv[3], hv[0], hv[1]});
      restart();
    endfunction

    // Check one accepted digest against the oldest owed one
    function void check_digest(bit [255:0] got);
      bit [255:0] exp_d;
      digests++;
      if (owed.size() == 0) begin
        $error("digest with none owed: %h", got);
        errors++;
        return;
      end
      exp_d = owed.pop_front();
      for (int k = 0; k < 4; k++)
        if (got[64*k +: 64] !== exp_d[64*k +: 64]) begin
          $error("digest_word_%0d expected %h actual %h", k, exp_d[64*k +: 64],
                 got[64*k +: 64]);
          errors++;
        end
    endfunction
  endclass

  digest_board board;
  int  cycles;
  bit  long_hold;
  bit  hold_issued;
  bit  sending_done;
  int  sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch the cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("[sha256_byte_stream_hasher_core] ERROR");
      $finish;
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      board.note_request(in_tdata, in_tuser, in_tlast);
    if (rst_n && out_tvalid && out_tready)
      board.check_digest(out_tdata);
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(bit [7:0] b, bit present, bit last, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= present;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_message(int len, bit empty_end, bit burst);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0, burst);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !empty_end, burst);
    end
    if (empty_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1, burst);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(negedge clk);
  endtask

  initial begin
    int len;
    bit burst;
    board = new();
    cycles = 0;
    sent = 0;
    long_hold = 1'b0;
    hold_issued = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty message, extreme bytes, byte with end, lone idle items, spills
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1, 1'b0);
    send_item(8'ha5, 1'b1, 1'b1, 1'b0);
    wait_drained();
    send_message(55, 1'b0, 1'b1);
    send_message(56, 1'b1, 1'b1);
    send_message(64, 1'b0, 1'b1);
    wait_drained();

    // Random messages; one long receiver hold with the sender bursting
    while (sent < 1900) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 70);
      burst = $urandom_range(0, 4) == 0;
      if (sent > 600 && !hold_issued) begin
        long_hold = 1'b1;
        hold_issued = 1'b1;
        burst = 1'b1;
      end
      send_message(len, $urandom_range(0, 3) == 0, burst);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
    repeat (300) @(negedge clk);

    $display("Sent %0d requests, checked %0d digests, including pad spills and empty ends.",
             sent, board.digests);
    if (board.errors == 0) begin
      $display("[sha256_byte_stream_hasher_core] OK");
    end else begin
      $display("[sha256_byte_stream_hasher_core] ERROR");
    end
    $finish;
  end

endmodule
